// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define OQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define OQS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define OQS_ASSERT(lbl, prop, msg)
`define OQS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: rtl/oqs_pkg.sv
// ----------------------------------------------------------------------------
// Order queue to shelf stack package
// Shared widths, operation codes and command types.
// ----------------------------------------------------------------------------
package oqs_pkg;

  localparam int CODE_W    = 8;
  localparam int MODE_W    = 2;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int IN_W      = 8;
  localparam int OUT_W     = 1 + CODE_W + 3 * CNT_W;

  // Largest limit the configuration registers can express.
  localparam int LIMIT_MAX = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(10);

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHELF_LIMIT = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ  = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_POP  = 2'd2
  } oqs_mode_t;

  // Push and pop strobes for the queue and for the stack cells.
  typedef struct packed {
    logic push;
    logic pop;
  } oqs_cmd_t;

endpackage

// File: rtl/oqs_cell.sv
// ----------------------------------------------------------------------------
// Stack cell
// One stack slot; on a push it takes the word from the cell above, on a pop
// the word from the cell below.
// ----------------------------------------------------------------------------
module oqs_cell (
  input  logic                      clk,
  input  oqs_pkg::oqs_cmd_t         cmd,
  input  logic [oqs_pkg::CODE_W-1:0] from_up,
  input  logic [oqs_pkg::CODE_W-1:0] from_down,
  output logic [oqs_pkg::CODE_W-1:0] value_r
);
  import oqs_pkg::*;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      value_r <= from_up;
    end else if (cmd.pop) begin
      value_r <= from_down;
    end
  end

endmodule

// File: rtl/oqs_queue.sv
// ----------------------------------------------------------------------------
// Order queue
// Circular buffer of type codes whose pointers wrap at the active limit.
// ----------------------------------------------------------------------------
module oqs_queue #(
  parameter int SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  oqs_pkg::oqs_cmd_t          cmd,
  input  logic [oqs_pkg::CODE_W-1:0] push_data,
  input  logic [oqs_pkg::CNT_W-1:0]  lim,
  output logic [oqs_pkg::CNT_W-1:0]  count,
  output logic [oqs_pkg::CODE_W-1:0] front
);
  import oqs_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  logic [CODE_W-1:0] store_r [SLOTS];
  logic [IDX_W-1:0]  head_r;
  logic [IDX_W-1:0]  tail_r;
  logic [CNT_W-1:0]  count_r;

  // A pointer goes back to zero once it reaches or passes the limit, which
  // matters when the limit was lowered while entries were held.
  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] limit);
    logic [CNT_W-1:0] nx;
    nx = CNT_W'(idx) + CNT_W'(1);
    return (nx >= limit) ? '0 : nx[IDX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      store_r[tail_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.push) begin
        tail_r  <= wrap_next(tail_r, lim);
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.pop) begin
        head_r  <= wrap_next(head_r, lim);
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  assign count = count_r;
  assign front = store_r[head_r];

endmodule

// File: rtl/order_queue_to_shelf_stack_unit.sv
// ----------------------------------------------------------------------------
// Order queue to shelf stack unit
// Enqueues type codes, moves the queue onto a shelf stack, pops the stack.
// ----------------------------------------------------------------------------
// Enqueue, pop and the unused mode: the result word is registered in the cycle after
// acceptance; one word per cycle sustained while out_tready stays high.
// Move: entries go one at a time through the stack cell chain until the queue empties or
// the stack reaches its limit, then the result word is registered; the next word can be accepted.
// Reset clears counts, pointers and the state; both limits return to 10.
// Queue and stack contents are not cleared.
module order_queue_to_shelf_stack_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int STACK_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [oqs_pkg::IN_W-1:0]      in_tdata,   // [7:0] type_code
  input  logic [oqs_pkg::MODE_W-1:0]    in_tuser,   // [1:0] mode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] success, [8:1] popped_code, [13:9] moved_count, [18:14] queue_count,
  // [23:19] stack_count
  output logic [oqs_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_we,
  input  logic [oqs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [oqs_pkg::CNT_W-1:0]     cfg_data
);
  import oqs_pkg::*;
  `include "assert_macros.svh"

  // Only slots below the largest expressible limit can ever be reached.
  localparam int Q_SLOTS = (QUEUE_DEPTH < LIMIT_MAX) ? QUEUE_DEPTH : LIMIT_MAX;
  localparam int S_SLOTS = (STACK_DEPTH < LIMIT_MAX) ? STACK_DEPTH : LIMIT_MAX;
  localparam logic [CNT_W-1:0] Q_CAP = CNT_W'(Q_SLOTS);
  localparam logic [CNT_W-1:0] S_CAP = CNT_W'(S_SLOTS);

  typedef enum logic {ST_IDLE, ST_MOVE} state_t;

  function automatic logic [CNT_W-1:0] clamp_lim(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > cap) begin
      r = cap;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [CNT_W-1:0] queue_lim_r, shelf_lim_r;
  logic [CNT_W-1:0] qlim, slim;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  s_count_r, s_count_nxt;
  logic [CNT_W-1:0]  moved_r, moved_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic              out_success_r, out_success_nxt;
  logic [CODE_W-1:0] out_popped_r, out_popped_nxt;
  logic [CNT_W-1:0]  out_moved_r, out_moved_nxt;
  logic [CNT_W-1:0]  out_qcount_r, out_qcount_nxt;
  logic [CNT_W-1:0]  out_scount_r, out_scount_nxt;

  oqs_cmd_t          q_cmd, s_cmd;
  logic [CNT_W-1:0]  q_count;
  logic [CODE_W-1:0] q_front;
  logic [CODE_W-1:0] cell_val [S_SLOTS];

  logic      accept, out_free, can_move;
  oqs_mode_t mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_lim_r <= LIMIT_RESET;
      shelf_lim_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUEUE_LIMIT: queue_lim_r <= cfg_data;
        CFG_SHELF_LIMIT: shelf_lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign qlim = clamp_lim(queue_lim_r, Q_CAP);
  assign slim = clamp_lim(shelf_lim_r, S_CAP);

  oqs_queue #(.SLOTS(Q_SLOTS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .push_data (in_tdata[CODE_W-1:0]),
    .lim       (qlim),
    .count     (q_count),
    .front     (q_front)
  );

  // Stack as a chain of cells, top of stack in cell 0. A move pushes the
  // queue front into cell 0 while every cell hands its word one place down.
  for (genvar g = 0; g < S_SLOTS; g++) begin : g_cell
    logic [CODE_W-1:0] up_val, down_val;
    if (g == 0) begin : g_top
      assign up_val = q_front;
    end else begin : g_mid
      assign up_val = cell_val[g-1];
    end
    if (g == S_SLOTS - 1) begin : g_bottom
      assign down_val = '0;
    end else begin : g_above
      assign down_val = cell_val[g+1];
    end
    oqs_cell u_cell (
      .clk       (clk),
      .cmd       (s_cmd),
      .from_up   (up_val),
      .from_down (down_val),
      .value_r   (cell_val[g])
    );
  end

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign mode      = oqs_mode_t'(in_tuser);
  assign can_move  = (q_count != '0) && (s_count_r < slim);

  always_comb begin
    state_nxt       = state_r;
    s_count_nxt     = s_count_r;
    moved_nxt       = moved_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_success_nxt = out_success_r;
    out_popped_nxt  = out_popped_r;
    out_moved_nxt   = out_moved_r;
    out_qcount_nxt  = out_qcount_r;
    out_scount_nxt  = out_scount_r;
    q_cmd           = '0;
    s_cmd           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_success_nxt = 1'b0;
          out_popped_nxt  = '0;
          out_moved_nxt   = '0;
          out_qcount_nxt  = q_count;
          out_scount_nxt  = s_count_r;
          unique case (mode)
            MODE_ENQ: begin
              out_tvalid_nxt = 1'b1;
              if (q_count < qlim) begin
                q_cmd.push      = 1'b1;
                out_success_nxt = 1'b1;
                out_qcount_nxt  = q_count + CNT_W'(1);
              end
            end
            MODE_MOVE: begin
              moved_nxt = '0;
              state_nxt = ST_MOVE;
            end
            MODE_POP: begin
              out_tvalid_nxt = 1'b1;
              if (s_count_r != '0) begin
                s_cmd.pop       = 1'b1;
                s_count_nxt     = s_count_r - CNT_W'(1);
                out_success_nxt = 1'b1;
                out_popped_nxt  = cell_val[0];
                out_scount_nxt  = s_count_r - CNT_W'(1);
              end
            end
            default: begin
              out_tvalid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_MOVE: begin
        if (can_move) begin
          q_cmd.pop   = 1'b1;
          s_cmd.push  = 1'b1;
          s_count_nxt = s_count_r + CNT_W'(1);
          moved_nxt   = moved_r + CNT_W'(1);
        end else if (out_free) begin
          out_tvalid_nxt  = 1'b1;
          out_success_nxt = 1'b1;
          out_popped_nxt  = '0;
          out_moved_nxt   = moved_r;
          out_qcount_nxt  = q_count;
          out_scount_nxt  = s_count_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      s_count_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      s_count_r    <= s_count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    moved_r       <= moved_nxt;
    out_success_r <= out_success_nxt;
    out_popped_r  <= out_popped_nxt;
    out_moved_r   <= out_moved_nxt;
    out_qcount_r  <= out_qcount_nxt;
    out_scount_r  <= out_scount_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_scount_r, out_qcount_r, out_moved_r, out_popped_r, out_success_r};

  // The stack never grows past the cells that back it.
  `OQS_ASSERT(a_stack_cap, s_count_r <= S_CAP, "stack count exceeds cell chain")
  // A move step only transfers entries; the total held stays the same.
  `OQS_ASSERT(a_move_conserve,
              (state_r == ST_MOVE) |=>
                (((CNT_W+1)'(q_count) + (CNT_W+1)'(s_count_r)) ==
                 $past((CNT_W+1)'(q_count) + (CNT_W+1)'(s_count_r))),
              "move step lost or created an entry")
  // A successful pop lowers the stack count by exactly one.
  `OQS_ASSERT(a_pop_dec,
              (accept && (mode == MODE_POP) && (s_count_r != '0)) |=>
                (s_count_r == $past(s_count_r) - CNT_W'(1)),
              "pop did not lower the stack count")
  // No word is handed to the output while a move is still transferring.
  `OQS_ASSERT_NEVER(a_move_no_early_result,
                    (state_r == ST_MOVE) && can_move && out_tvalid_nxt &&
                      !(out_tvalid_r && !out_tready),
                    "result issued before move finished")

endmodule

// File: verif/order_queue_to_shelf_stack_unit_test.sv
// ----------------------------------------------------------------------------
// Order queue to shelf stack unit testbench
// Streams enqueue, move and pop words into the unit with random gaps on both
// sides. A scoreboard predicts every result word and compares it field by
// field. Both limits are reprogrammed between phases, clamped extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module order_queue_to_shelf_stack_unit_test;
  import oqs_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int DEPTH       = 16;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 50;
  localparam int LONG_HOLD   = 300;

  // Same layout as out_tdata, success in bit 0.
  typedef struct packed {
    logic [CNT_W-1:0]  stack_count;
    logic [CNT_W-1:0]  queue_count;
    logic [CNT_W-1:0]  moved_count;
    logic [CODE_W-1:0] popped_code;
    logic              success;
  } shelf_result_t;

  class shelf_scoreboard;
    shelf_result_t     pending_results[$];
    logic [CODE_W-1:0] queue_mem[DEPTH];
    logic [CODE_W-1:0] stack_mem[DEPTH];
    logic [CNT_W-1:0]  queue_limit;
    logic [CNT_W-1:0]  shelf_limit;
    int queue_head, queue_tail, queue_fill, stack_fill;
    int errors;
    int n_enq, n_enq_full, n_move, n_moved, n_pop, n_pop_empty, n_unused, n_settings;

    function new();
      queue_limit = LIMIT_RESET;
      shelf_limit = LIMIT_RESET;
    endfunction

    function int effective(logic [CNT_W-1:0] lim);
      if (lim == 0) return 1;
      if (lim > DEPTH) return DEPTH;
      return int'(lim);
    endfunction

    function void set_limits(logic [CNT_W-1:0] qlim, logic [CNT_W-1:0] slim);
      queue_limit = qlim;
      shelf_limit = slim;
      n_settings++;
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 40) begin
        $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
      end
    endtask

    function void note_order(logic [MODE_W-1:0] mode, logic [CODE_W-1:0] code);
      shelf_result_t r;
      int ql, sl, moved;
      r = '0;
      moved = 0;
      ql = effective(queue_limit);
      sl = effective(shelf_limit);
      case (mode)
        MODE_ENQ: begin
          n_enq++;
          if (queue_fill < ql) begin
            queue_mem[queue_tail] = code;
            queue_tail = (queue_tail + 1 >= ql) ? 0 : queue_tail + 1;
            queue_fill++;
            r.success = 1'b1;
          end else begin
            n_enq_full++;
          end
        end
        MODE_MOVE: begin
          n_move++;
          r.success = 1'b1;
          // The head wraps against the current limit, even when it already
          // stands beyond it after a limit change.
          while (queue_fill != 0 && stack_fill < sl) begin
            stack_mem[stack_fill] = queue_mem[queue_head];
            queue_head = (queue_head + 1 >= ql) ? 0 : queue_head + 1;
            queue_fill--;
            stack_fill++;
            moved++;
          end
          n_moved += moved;
          r.moved_count = CNT_W'(moved);
        end
        MODE_POP: begin
          n_pop++;
          if (stack_fill != 0) begin
            stack_fill--;
            r.popped_code = stack_mem[stack_fill];
            r.success = 1'b1;
          end else begin
            n_pop_empty++;
          end
        end
        default: n_unused++;
      endcase
      r.queue_count = CNT_W'(queue_fill);
      r.stack_count = CNT_W'(stack_fill);
      pending_results.push_back(r);
    endfunction

    task check_result(logic [OUT_W-1:0] word);
      shelf_result_t got, want;
      got = shelf_result_t'(word);
      if (pending_results.size() == 0) begin
        report("word with no order outstanding", 32'(word), 0);
        return;
      end
      want = pending_results.pop_front();
      if (got.success !== want.success)
        report("success", 32'(got.success), 32'(want.success));
      if (got.popped_code !== want.popped_code)
        report("popped_code", 32'(got.popped_code), 32'(want.popped_code));
      if (got.moved_count !== want.moved_count)
        report("moved_count", 32'(got.moved_count), 32'(want.moved_count));
      if (got.queue_count !== want.queue_count)
        report("queue_count", 32'(got.queue_count), 32'(want.queue_count));
      if (got.stack_count !== want.stack_count)
        report("stack_count", 32'(got.stack_count), 32'(want.stack_count));
    endtask

    task finish_check();
      if (pending_results.size() != 0)
        report("results never delivered", 0, pending_results.size());
    endtask
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic [IN_W-1:0]      in_tdata   = '0;
  logic [MODE_W-1:0]    in_tuser   = '0;
  logic                 out_tready = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CNT_W-1:0]     cfg_data   = '0;
  wire                  in_tready;
  wire                  out_tvalid;
  wire  [OUT_W-1:0]     out_tdata;

  bit offering     = 1'b0;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;

  shelf_scoreboard tracker = new();

  order_queue_to_shelf_stack_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return MODE_ENQ;
    if (r < 65) return MODE_MOVE;
    if (r < 95) return MODE_POP;
    return MODE_UNUSED;
  endfunction

  function automatic logic [CNT_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CNT_W'(1);
      2: return CNT_W'(DEPTH);
      3: return CNT_W'(DEPTH + 1);
      4: return CNT_W'(LIMIT_MAX);
      default: return CNT_W'($urandom_range(2, DEPTH - 1));
    endcase
  endfunction

  task automatic lower_valid();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_word(logic [MODE_W-1:0] mode, logic [CODE_W-1:0] code);
    int gap;
    if (!offering) in_tvalid <= 1'b1;
    offering = 1'b1;
    in_tuser <= mode;
    in_tdata <= code;
    do @(posedge clk); while (!in_tready);
    tracker.note_order(mode, code);
    gap = (!calm && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      lower_valid();
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every result word is back.
  task automatic drain();
    lower_valid();
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limits(logic [CNT_W-1:0] qlim, logic [CNT_W-1:0] slim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_QUEUE_LIMIT;
    cfg_data  <= qlim;
    @(posedge clk);
    cfg_index <= CFG_SHELF_LIMIT;
    cfg_data  <= slim;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_limits(qlim, slim);
  endtask

  initial begin : stimulus
    int n, p;
    logic [CNT_W-1:0] qlim, slim;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both structures empty, reset limits.
    send_word(MODE_POP, 8'h3C);
    send_word(MODE_MOVE, 8'hC3);
    send_word(MODE_UNUSED, 8'hFF);
    drain();

    // Fill the whole queue so that every cell holds a written code, then move
    // it all at once; the shelf limit above the depth acts as the depth.
    write_limits(CNT_W'(DEPTH), CNT_W'(LIMIT_MAX));
    send_word(MODE_ENQ, 8'h00);
    send_word(MODE_ENQ, 8'hFF);
    for (n = 0; n < DEPTH - 2; n++) send_word(MODE_ENQ, CODE_W'($urandom_range(1, 254)));
    send_word(MODE_ENQ, 8'h81);
    send_word(MODE_MOVE, 8'h00);
    send_word(MODE_POP, 8'h00);
    drain();

    // A queue limit of zero acts as one; the stack already holds more than
    // its new limit, so the move stops at once.
    write_limits('0, CNT_W'(1));
    send_word(MODE_ENQ, 8'h55);
    send_word(MODE_ENQ, 8'hAA);
    send_word(MODE_MOVE, 8'h00);
    drain();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin qlim = CNT_W'(1);         slim = CNT_W'(DEPTH); end
        3: begin qlim = CNT_W'(DEPTH);     slim = CNT_W'(1);     end
        6: begin qlim = CNT_W'(LIMIT_MAX); slim = '0;            end
        default: begin qlim = pick_limit(); slim = pick_limit(); end
      endcase
      write_limits(qlim, slim);
      calm = (p % 4 == 1);
      // The receiver holds off long enough for the unit to back up its input.
      if (p == 2) hold_request <= 1'b1;
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (p == 5 && n == PHASE_WORDS / 2) drain();
        send_word(pick_mode(), CODE_W'($urandom_range(0, 255)));
      end
      drain();
    end

    tracker.finish_check();
    $display("%0d enqueue (%0d refused), %0d move (%0d entries moved),",
             tracker.n_enq, tracker.n_enq_full, tracker.n_move, tracker.n_moved);
    $display("%0d pop (%0d empty), %0d unused",
             tracker.n_pop, tracker.n_pop_empty, tracker.n_unused);
    $display("%0d limit settings with zero, one, the depth and above it; one %0d-cycle hold-off",
             tracker.n_settings, LONG_HOLD);
    if (tracker.errors == 0) begin
      $display("order_queue_to_shelf_stack_unit_test: done, clean");
    end else begin
      $display("order_queue_to_shelf_stack_unit_test: done, errors");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    stall = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) tracker.check_result(out_tdata);
      if (hold_request) begin
        hold_request <= 1'b0;
        stall = LONG_HOLD;
      end else if (stall == 0 && !calm && $urandom_range(0, 4) == 0) begin
        stall = idle_len();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("order_queue_to_shelf_stack_unit_test: done, errors");
    $finish;
  end

endmodule

// File: order_queue_to_shelf_stack_unit.f
+incdir+rtl
rtl/oqs_pkg.sv
rtl/oqs_cell.sv
rtl/oqs_queue.sv
rtl/order_queue_to_shelf_stack_unit.sv
verif/order_queue_to_shelf_stack_unit_test.sv
